@@ rtl/core/grq_pkg.sv @@
// ----------------------------------------------------------------------------
// grq_pkg: shared types and constants for the graph reachability query block
// Node limits, opcodes and the command/status bundles between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package grq_pkg;

    // Graph geometry
    localparam int MAX_NODES = 64;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int IDX_W     = 6;
    localparam int ROW_W     = 64;
    localparam int CNT_W     = 7;

    // Opcodes of an input transaction
    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic clear;
        logic edge_rd_a;
        logic edge_wr_a;
        logic edge_rd_b;
        logic edge_wr_b;
        logic q_init;
        logic q_pick;
        logic q_merge;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic [1:0] op;
        logic       oor;
        logic       goal_hit;
        logic       pending_empty;
    } t_dp_sts;

endpackage

@@ rtl/core/graph_reachability_query.sv @@
// ----------------------------------------------------------------------------
// graph_reachability_query: undirected graph edge store and path query
// Stores up to 64 nodes as adjacency rows and answers source-to-destination
// reachability by walking the graph one node at a time.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken when start is high and busy is low; i_op selects
//   add edge (i_node_a, i_node_b), path query (source i_node_a, destination
//   i_node_b) or clear graph. One result per transaction appears on
//   o_reachable/o_status for one cycle with o_done high; it must be taken
//   then, since the receiver has no way to stall it.
//   Each expanded node of a query costs one read of the adjacency memory
//   and one merge step. busy stays high until o_done, so the next
//   transaction can start in the o_done cycle.
//   The node count is written through i_cfg_valid/o_cfg_ready/i_cfg_data;
//   the user must write it only while idle, which the block does not enforce;
//   o_cfg_ready is always high. Reset sets the node count to 64 and empties
//   the graph at once via per-row valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
module graph_reachability_query (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 i_op,
    input  logic [grq_pkg::IDX_W-1:0]  i_node_a,
    input  logic [grq_pkg::IDX_W-1:0]  i_node_b,
    output logic                       o_done,
    output logic                       o_reachable,
    output logic                       o_status,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [grq_pkg::CNT_W-1:0]  i_cfg_data
);
    import grq_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    assign o_cfg_ready = 1'b1;

    grq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd),
        .o_done      (o_done),
        .o_reachable (o_reachable),
        .o_status    (o_status)
    );

    grq_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dp_cmd),
        .o_sts      (dp_sts),
        .i_op       (i_op),
        .i_node_a   (i_node_a),
        .i_node_b   (i_node_b),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

`ifndef SYNTH
    // An accepted transaction keeps the block busy in the next cycle
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted transaction");

    // Result strobes never come back to back
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for two cycles");

    // The result strobe comes only when idle again
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // An out-of-range status never reports a path
    a_status_reach: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status) |-> !o_reachable)
        else $error("reachable set with out-of-range status");
`endif

endmodule

@@ rtl/core/grq_ctrl.sv @@
// ----------------------------------------------------------------------------
// grq_ctrl: sequencing controller
// Decodes each transaction and steps the datapath through edge insertion,
// graph clear or the reachability walk, then drives the result strobe.
// ----------------------------------------------------------------------------
module grq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  grq_pkg::t_dp_sts  i_sts,
    output grq_pkg::t_dp_cmd  o_cmd,
    output logic              o_done,
    output logic              o_reachable,
    output logic              o_status
);
    import grq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_EDGE_RD_A,
        S_EDGE_WR_A,
        S_EDGE_RD_B,
        S_EDGE_WR_B,
        S_Q_PICK,
        S_Q_MERGE
    } t_state;

    t_state r_state;
    logic   r_done;
    logic   r_reach;
    logic   r_status;

    // Decode commands from the current state
    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.load = start;
            end
            S_DECODE: begin
                o_cmd.clear  = (i_sts.op == OP_CLEAR);
                o_cmd.q_init = (i_sts.op == OP_QUERY) && !i_sts.oor;
            end
            S_EDGE_RD_A: o_cmd.edge_rd_a = 1'b1;
            S_EDGE_WR_A: o_cmd.edge_wr_a = 1'b1;
            S_EDGE_RD_B: o_cmd.edge_rd_b = 1'b1;
            S_EDGE_WR_B: o_cmd.edge_wr_b = 1'b1;
            S_Q_PICK: begin
                o_cmd.q_pick = !i_sts.goal_hit && !i_sts.pending_empty;
            end
            S_Q_MERGE: o_cmd.q_merge = 1'b1;
            default: o_cmd = '0;
        endcase
    end

    // Advance state and register the result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_done   <= 1'b0;
            r_reach  <= 1'b0;
            r_status <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) r_state <= S_DECODE;
                end
                S_DECODE: begin
                    case (i_sts.op)
                        OP_ADD: begin
                            if (i_sts.oor) begin
                                r_state  <= S_IDLE;
                                r_done   <= 1'b1;
                                r_reach  <= 1'b0;
                                r_status <= 1'b1;
                            end else begin
                                r_state <= S_EDGE_RD_A;
                            end
                        end
                        OP_QUERY: begin
                            if (i_sts.oor) begin
                                r_state  <= S_IDLE;
                                r_done   <= 1'b1;
                                r_reach  <= 1'b0;
                                r_status <= 1'b1;
                            end else begin
                                r_state <= S_Q_PICK;
                            end
                        end
                        default: begin
                            r_state  <= S_IDLE;
                            r_done   <= 1'b1;
                            r_reach  <= 1'b0;
                            r_status <= 1'b0;
                        end
                    endcase
                end
                S_EDGE_RD_A: r_state <= S_EDGE_WR_A;
                S_EDGE_WR_A: r_state <= S_EDGE_RD_B;
                S_EDGE_RD_B: r_state <= S_EDGE_WR_B;
                S_EDGE_WR_B: begin
                    r_state  <= S_IDLE;
                    r_done   <= 1'b1;
                    r_reach  <= 1'b0;
                    r_status <= 1'b0;
                end
                S_Q_PICK: begin
                    if (i_sts.goal_hit) begin
                        r_state  <= S_IDLE;
                        r_done   <= 1'b1;
                        r_reach  <= 1'b1;
                        r_status <= 1'b0;
                    end else if (i_sts.pending_empty) begin
                        r_state  <= S_IDLE;
                        r_done   <= 1'b1;
                        r_reach  <= 1'b0;
                        r_status <= 1'b0;
                    end else begin
                        r_state <= S_Q_MERGE;
                    end
                end
                S_Q_MERGE: r_state <= S_Q_PICK;
                default:   r_state <= S_IDLE;
            endcase
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_done      = r_done;
    assign o_reachable = r_reach;
    assign o_status    = r_status;

endmodule

@@ rtl/core/grq_datapath.sv @@
// ----------------------------------------------------------------------------
// grq_datapath: adjacency memory and walk registers
// Holds the node count, the adjacency row memory with per-row valid bits,
// the latched transaction and the visited/pending sets of a query.
// ----------------------------------------------------------------------------
module grq_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  grq_pkg::t_dp_cmd                  i_cmd,
    output grq_pkg::t_dp_sts                  o_sts,
    input  logic [1:0]                        i_op,
    input  logic [grq_pkg::IDX_W-1:0]         i_node_a,
    input  logic [grq_pkg::IDX_W-1:0]         i_node_b,
    input  logic                              i_cfg_we,
    input  logic [grq_pkg::CNT_W-1:0]         i_cfg_data
);
    import grq_pkg::*;

    // Configuration and latched transaction
    logic [CNT_W-1:0] r_node_count;
    logic [1:0]       r_op;
    logic [IDX_W-1:0] r_a;
    logic [IDX_W-1:0] r_b;

    // Adjacency memory, row valid bits and registered read port
    logic [ROW_W-1:0] r_adj [MAX_NODES];
    logic             r_row_valid [MAX_NODES];
    logic [ROW_W-1:0] r_rd_data;
    logic             r_rd_valid;

    // Walk state
    logic [ROW_W-1:0] r_visited;
    logic [ROW_W-1:0] r_pending;

    logic [CNT_W-1:0]  n_eff;
    logic [ROW_W-1:0]  node_mask;
    logic [ROW_W-1:0]  goal;
    logic [ROW_W-1:0]  low_bit;
    logic [IDX_W-1:0]  pick_idx;
    logic [ROW_W-1:0]  row_q;
    logic [ROW_W-1:0]  new_nodes;
    logic              rd_en;
    logic [NODE_W-1:0] rd_addr;
    logic              wr_en;
    logic [NODE_W-1:0] wr_addr;
    logic [ROW_W-1:0]  wr_data;

    // Saturate node count and build the in-use node mask
    always_comb begin
        n_eff = (r_node_count > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : r_node_count;
        for (int i = 0; i < ROW_W; i++) begin
            node_mask[i] = (CNT_W'(i) < n_eff);
        end
    end

    // Isolate and encode the lowest pending node
    always_comb begin
        low_bit  = r_pending & (~r_pending + ROW_W'(1));
        pick_idx = '0;
        for (int i = 0; i < ROW_W; i++) begin
            for (int j = 0; j < IDX_W; j++) begin
                if (((i >> j) & 1) == 1) pick_idx[j] = pick_idx[j] | low_bit[i];
            end
        end
    end

    // Memory read and write steering
    always_comb begin
        row_q     = r_rd_valid ? r_rd_data : '0;
        goal      = ROW_W'(1) << r_b;
        new_nodes = row_q & node_mask & ~r_visited;
        rd_en     = i_cmd.edge_rd_a | i_cmd.edge_rd_b | i_cmd.q_pick;
        rd_addr   = i_cmd.edge_rd_a ? r_a[NODE_W-1:0] :
                    i_cmd.edge_rd_b ? r_b[NODE_W-1:0] : pick_idx[NODE_W-1:0];
        wr_en     = i_cmd.edge_wr_a | i_cmd.edge_wr_b;
        wr_addr   = i_cmd.edge_wr_a ? r_a[NODE_W-1:0] : r_b[NODE_W-1:0];
        wr_data   = row_q | (i_cmd.edge_wr_a ? (ROW_W'(1) << r_b) : (ROW_W'(1) << r_a));
    end

    // Hold the node count register and latch each transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= CNT_W'(MAX_NODES);
        end else if (i_cfg_we) begin
            r_node_count <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_op;
            r_a  <= i_node_a;
            r_b  <= i_node_b;
        end
    end

    // Adjacency rows: write one row, read one row registered
    always_ff @(posedge i_clk) begin
        if (wr_en) r_adj[wr_addr] <= wr_data;
        if (rd_en) r_rd_data <= r_adj[rd_addr];
    end

    // Row valid bits: drop all on reset or clear
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            for (int i = 0; i < MAX_NODES; i++) r_row_valid[i] <= 1'b0;
            r_rd_valid <= 1'b0;
        end else begin
            if (wr_en) r_row_valid[wr_addr] <= 1'b1;
            if (rd_en) r_rd_valid <= r_row_valid[rd_addr];
        end
    end

    // Visited and pending sets of the walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_visited <= '0;
            r_pending <= '0;
        end else if (i_cmd.q_init) begin
            r_visited <= ROW_W'(1) << r_a;
            r_pending <= ROW_W'(1) << r_a;
        end else if (i_cmd.q_pick) begin
            r_pending <= r_pending & ~low_bit;
        end else if (i_cmd.q_merge) begin
            r_visited <= r_visited | new_nodes;
            r_pending <= r_pending | new_nodes;
        end
    end

    // Status back to the controller
    always_comb begin
        o_sts.op            = r_op;
        o_sts.oor           = ({1'b0, r_a} >= n_eff) || ({1'b0, r_b} >= n_eff);
        o_sts.goal_hit      = |(r_visited & goal);
        o_sts.pending_empty = (r_pending == '0);
    end

endmodule
